// ===== hw/rtl/us2c_pkg.sv =====
// shared types and constants for the unix seconds to calendar converter
package us2c_pkg;

	localparam int NSTAGE = 8;

	typedef struct packed {
		logic [NSTAGE-1:0] en;
	} us2c_ctrl_t;

	localparam logic [25:0] RECIP_675   = 26'd50903317;
	localparam logic [16:0] SECS_DAY    = 17'd86400;
	localparam logic [17:0] DAYS_SHIFT  = 18'd135080;
	localparam logic [17:0] DAYS_400Y   = 18'd146097;
	localparam logic [16:0] RECIP_7     = 17'd74899;
	localparam logic [15:0] WDAY_OFFS   = 16'd4;
	localparam logic [17:0] DAYS_100Y   = 18'd36524;
	localparam logic [16:0] RECIP_1461  = 17'd91868;
	localparam logic [10:0] DAYS_4Y     = 11'd1461;
	localparam logic [10:0] DAYS_1Y     = 11'd365;
	localparam logic [13:0] RECIP_225   = 14'd9321;
	localparam logic [11:0] SECS_HOUR   = 12'd3600;
	localparam logic [10:0] RECIP_15    = 11'd1093;
	localparam logic [11:0] SECS_MIN    = 12'd60;
	localparam logic [5:0]  QUAD_MAX    = 6'd24;
	localparam logic [8:0]  JAN_FEB     = 9'd59;

	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};

endpackage

// ===== hw/rtl/us2c_pipe_ctrl.sv =====
// valid bits and per-stage enables of the conversion pipeline
module us2c_pipe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output us2c_pkg::us2c_ctrl_t ctrl
);
	import us2c_pkg::*;

	logic [NSTAGE-1:0] stage_vld_q;
	logic [NSTAGE-1:0] en;

	always_comb begin
		en[NSTAGE-1] = !stage_vld_q[NSTAGE-1] || out_ready;
		for (int k = NSTAGE-2; k >= 0; k--) begin
			en[k] = !stage_vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en[0]) stage_vld_q[0] <= in_valid;
			for (int k = 1; k < NSTAGE; k++) begin
				if (en[k]) stage_vld_q[k] <= stage_vld_q[k-1];
			end
		end
	end

	assign ctrl.en    = en;
	assign in_ready   = en[0];
	assign out_valid  = stage_vld_q[NSTAGE-1];

endmodule

// ===== hw/rtl/us2c_day_split.sv =====
// split of the timestamp into whole days and seconds of the day
module us2c_day_split (
	input  logic                 clk,
	input  us2c_pkg::us2c_ctrl_t ctrl,
	input  logic [31:0]          unix_seconds,
	output logic [15:0]          days_s2,
	output logic [16:0]          tod_s2
);
	import us2c_pkg::*;

	logic [50:0] prod;
	logic [15:0] q_s1;
	logic [16:0] low_s1;
	logic [32:0] qmul;

	assign prod = 51'(unix_seconds[31:7]) * 51'(RECIP_675);
	assign qmul = 33'(q_s1) * 33'(SECS_DAY);

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			q_s1   <= prod[50:35];
			low_s1 <= unix_seconds[16:0];
		end
		if (ctrl.en[1]) begin
			days_s2 <= q_s1;
			tod_s2  <= low_s1 - qmul[16:0];
		end
	end

endmodule

// ===== hw/rtl/us2c_tod_split.sv =====
// hour, minute and second from the seconds of the day
module us2c_tod_split (
	input  logic                 clk,
	input  us2c_pkg::us2c_ctrl_t ctrl,
	input  logic [16:0]          tod_s2,
	output logic [4:0]           hour_s8,
	output logic [5:0]           minute_s8,
	output logic [5:0]           second_s8
);
	import us2c_pkg::*;

	logic [26:0] hprod;
	logic [20:0] mprod;
	logic [16:0] tod_s3;
	logic [4:0]  hour_s3, hour_s4, hour_s5, hour_s6, hour_s7;
	logic [16:0] hmul;
	logic [11:0] rs_s4, rs_s5;
	logic [5:0]  min_s5, min_s6, min_s7;
	logic [11:0] mmul;
	logic [5:0]  sec_s6, sec_s7;

	assign hprod = 27'(tod_s2[16:4]) * 27'(RECIP_225);
	assign hmul  = 17'(hour_s3) * 17'(SECS_HOUR);
	assign mprod = 21'(rs_s4[11:2]) * 21'(RECIP_15);
	assign mmul  = 12'(min_s5) * SECS_MIN;

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			hour_s3 <= hprod[25:21];
			tod_s3  <= tod_s2;
		end
		if (ctrl.en[3]) begin
			hour_s4 <= hour_s3;
			rs_s4   <= 12'(tod_s3 - hmul);
		end
		if (ctrl.en[4]) begin
			hour_s5 <= hour_s4;
			rs_s5   <= rs_s4;
			min_s5  <= mprod[19:14];
		end
		if (ctrl.en[5]) begin
			hour_s6 <= hour_s5;
			min_s6  <= min_s5;
			sec_s6  <= 6'(rs_s5 - mmul);
		end
		if (ctrl.en[6]) begin
			hour_s7 <= hour_s6;
			min_s7  <= min_s6;
			sec_s7  <= sec_s6;
		end
		if (ctrl.en[7]) begin
			hour_s8   <= hour_s7;
			minute_s8 <= min_s7;
			second_s8 <= sec_s7;
		end
	end

endmodule

// ===== hw/rtl/us2c_date_calc.sv =====
// calendar date, weekday and day of year from the day count
module us2c_date_calc (
	input  logic                 clk,
	input  us2c_pkg::us2c_ctrl_t ctrl,
	input  logic [15:0]          days_s2,
	output logic [7:0]           year_s8,
	output logic [3:0]           month_s8,
	output logic [4:0]           mday_s8,
	output logic [2:0]           wday_s8,
	output logic [8:0]           yday_s8
);
	import us2c_pkg::*;

	// stage 3
	logic [17:0] dshift;
	logic [15:0] wv;
	logic [32:0] wprod;
	logic [17:0] rem400_s3;
	logic        era_neg_s3;
	logic [15:0] wv_s3;
	logic [13:0] wq_s3;
	// stage 4
	logic [1:0]  cent;
	logic [17:0] cent_off;
	logic [16:0] wmul;
	logic [15:0] rem100_s4;
	logic [1:0]  cent_s4, cent_s5, cent_s6, cent_s7;
	logic        era_neg_s4, era_neg_s5, era_neg_s6, era_neg_s7;
	logic [2:0]  wday_s4, wday_s5, wday_s6, wday_s7;
	// stage 5
	logic [32:0] qprod;
	logic [5:0]  qraw;
	logic [15:0] rem100_s5;
	logic [4:0]  quad_s5, quad_s6, quad_s7;
	// stage 6
	logic [15:0] qmul;
	logic [10:0] rem4_s6;
	// stage 7
	logic [1:0]  yr;
	logic [10:0] ymul;
	logic [8:0]  rem_s7;
	logic [1:0]  yr_s7;
	logic        leap_s7;
	// stage 8
	logic [3:0]  midx;
	logic [3:0]  mon3;
	logic        wrap;
	logic [9:0]  yday_raw;
	logic [9:0]  ylen;
	logic [10:0] base;
	logic [10:0] years;

	assign dshift = 18'(days_s2) + DAYS_SHIFT;
	assign wv     = days_s2 + WDAY_OFFS;
	assign wprod  = 33'(wv) * 33'(RECIP_7);

	always_comb begin
		if (rem400_s3 >= 18'(3) * DAYS_100Y) begin
			cent = 2'd3;
		end else if (rem400_s3 >= 18'(2) * DAYS_100Y) begin
			cent = 2'd2;
		end else if (rem400_s3 >= DAYS_100Y) begin
			cent = 2'd1;
		end else begin
			cent = 2'd0;
		end
		cent_off = 18'(cent) * DAYS_100Y;
	end
	assign wmul = 17'(wq_s3) * 17'd7;

	assign qprod = 33'(rem100_s4) * 33'(RECIP_1461);
	assign qraw  = qprod[32:27];

	assign qmul = 16'(quad_s5) * 16'(DAYS_4Y);

	always_comb begin
		if (rem4_s6 >= 11'(3) * DAYS_1Y) begin
			yr = 2'd3;
		end else if (rem4_s6 >= 11'(2) * DAYS_1Y) begin
			yr = 2'd2;
		end else if (rem4_s6 >= DAYS_1Y) begin
			yr = 2'd1;
		end else begin
			yr = 2'd0;
		end
		ymul = 11'(yr) * DAYS_1Y;
	end

	always_comb begin
		midx = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (rem_s7 >= MONTH_START[i]) midx = 4'(i);
		end
		wrap = (midx >= 4'd10);
		mon3 = wrap ? midx - 4'd9 : midx + 4'd3;
		ylen     = 10'(DAYS_1Y) + 10'(leap_s7);
		yday_raw = 10'(rem_s7) + 10'(JAN_FEB) + 10'(leap_s7);
		base = 11'(yr_s7) + 11'({quad_s7, 2'b00}) + 11'(cent_s7) * 11'd100
			+ 11'(wrap);
		years = era_neg_s7 ? base - 11'd400 : base;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			era_neg_s3 <= (dshift < DAYS_400Y);
			rem400_s3  <= (dshift < DAYS_400Y) ? dshift : dshift - DAYS_400Y;
			wv_s3      <= wv;
			wq_s3      <= wprod[32:19];
		end
		if (ctrl.en[3]) begin
			cent_s4    <= cent;
			rem100_s4  <= 16'(rem400_s3 - cent_off);
			era_neg_s4 <= era_neg_s3;
			wday_s4    <= 3'(17'(wv_s3) - wmul);
		end
		if (ctrl.en[4]) begin
			quad_s5    <= (qraw > QUAD_MAX) ? QUAD_MAX[4:0] : qraw[4:0];
			rem100_s5  <= rem100_s4;
			cent_s5    <= cent_s4;
			era_neg_s5 <= era_neg_s4;
			wday_s5    <= wday_s4;
		end
		if (ctrl.en[5]) begin
			rem4_s6    <= 11'(rem100_s5 - qmul);
			quad_s6    <= quad_s5;
			cent_s6    <= cent_s5;
			era_neg_s6 <= era_neg_s5;
			wday_s6    <= wday_s5;
		end
		if (ctrl.en[6]) begin
			yr_s7      <= yr;
			rem_s7     <= 9'(rem4_s6 - ymul);
			leap_s7    <= (yr == 2'd0) && (quad_s6 != 5'd0 || cent_s6 == 2'd0);
			quad_s7    <= quad_s6;
			cent_s7    <= cent_s6;
			era_neg_s7 <= era_neg_s6;
			wday_s7    <= wday_s6;
		end
		if (ctrl.en[7]) begin
			year_s8  <= years[7:0];
			month_s8 <= mon3;
			mday_s8  <= 5'(rem_s7 - MONTH_START[midx] + 9'd1);
			wday_s8  <= wday_s7;
			yday_s8  <= (yday_raw >= ylen) ? 9'(yday_raw - ylen) : yday_raw[8:0];
		end
	end

endmodule

// ===== hw/rtl/unix_seconds_to_calendar_core.sv =====
// top level of the unix seconds to utc calendar converter
// an accepted input beat passes through every pipeline stage, from the day split to the registered outputs
// throughput: one beat per cycle while out_ready is high; the constant-reciprocal multipliers are pipelined
// each stage stalls only when it holds a beat and the stage after it cannot take it
// reset clears the pipeline valid bits; data registers are not reset
module unix_seconds_to_calendar_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       unix_seconds,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] year_since_2000,
	output logic [3:0]        month_number,
	output logic [4:0]        day_of_month,
	output logic [4:0]        hour_of_day,
	output logic [5:0]        minute_of_hour,
	output logic [5:0]        second_of_minute,
	output logic [2:0]        weekday,
	output logic [8:0]        day_of_year
);
	import us2c_pkg::*;

	us2c_ctrl_t  ctrl;
	logic [15:0] days_s2;
	logic [16:0] tod_s2;
	logic [7:0]  year_s8;

	us2c_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	us2c_day_split u_day (
		.clk          (clk),
		.ctrl         (ctrl),
		.unix_seconds (unix_seconds),
		.days_s2      (days_s2),
		.tod_s2       (tod_s2)
	);

	us2c_tod_split u_tod (
		.clk       (clk),
		.ctrl      (ctrl),
		.tod_s2    (tod_s2),
		.hour_s8   (hour_of_day),
		.minute_s8 (minute_of_hour),
		.second_s8 (second_of_minute)
	);

	us2c_date_calc u_date (
		.clk      (clk),
		.ctrl     (ctrl),
		.days_s2  (days_s2),
		.year_s8  (year_s8),
		.month_s8 (month_number),
		.mday_s8  (day_of_month),
		.wday_s8  (weekday),
		.yday_s8  (day_of_year)
	);

	assign year_since_2000 = signed'(year_s8);

endmodule
